// ----- src/kpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad scan package
// Shared types and constants for the keypad scan and debounce core.
// ----------------------------------------------------------------------------
package kpsd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYMAP_HIGH = 2'd1;

  // Default keymap: '1','2','3',Up / '4','5','6',Left / '7','8','9',Down / '0',Esc,Enter,Right.
  localparam logic [63:0] KEYMAP_LOW_RST  = 64'd2681389126241169969;
  localparam logic [63:0] KEYMAP_HIGH_RST = 64'd2813935235823646775;

  // Fixed field widths of the matrix interface.
  localparam int LINE_W  = 4;
  localparam int INDEX_W = 4;
  localparam int CODE_W  = 8;

  // One finished scan tick, handed from the update stage to the result emitter.
  typedef struct packed {
    logic [1:0]        row;
    logic [LINE_W-1:0] drive;
    logic [LINE_W-1:0] mask;
  } tick_t;

endpackage

// ----- src/matrix_keypad_scan_debounce_core.sv -----
// ----------------------------------------------------------------------------
// Matrix keypad scan and debounce core
// Row-by-row key matrix scanner with per-key debounce and press reporting.
// ----------------------------------------------------------------------------
// Each request is one scan tick carrying the column levels of the row now
// driven. The block takes one tick per clock while in_stall is low; a tick
// gives one result when no key became pressed and one result per newly
// pressed key otherwise, so a tick with n presses holds the result port for
// n results and throttles input through a one-deep tick buffer. A taken tick
// passes the stage register, then the result buffer, before its first result
// is offered; a busy buffer can hold it between. The take edge launches the
// registered read of the row-state RAM; the edge that moves the tick into the
// buffer writes back the debounced row. Rows start out released through
// per-row valid flags, so no clearing pass is needed after reset.
module matrix_keypad_scan_debounce_core #(
  parameter int DEBOUNCE_SAMPLES = 4,
  parameter int ROWS             = 4,
  parameter int COLS             = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [kpsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kpsd_pkg::LINE_W-1:0]    in_column_levels,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kpsd_pkg::LINE_W-1:0]    out_row_drive,
  output logic                           out_press_valid,
  output logic [kpsd_pkg::INDEX_W-1:0]   out_key_index,
  output logic [kpsd_pkg::CODE_W-1:0]    out_key_code,
  output logic                           out_last_of_tick
);
  import kpsd_pkg::*;

  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ENTRY_W = COLS * (DEBOUNCE_SAMPLES + 1);

  logic [63:0]        keymap_low_r;
  logic [63:0]        keymap_high_r;
  logic [ROW_W-1:0]   cur_row_r;
  logic [ROW_W-1:0]   cur_row_nxt;
  logic [ROWS-1:0]    row_vld_r;
  logic               s1_valid_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [LINE_W-1:0]  s1_lvl_r;
  logic [LINE_W-1:0]  s1_drive_r;
  logic               s1_vld_r;
  logic               s1_hit_r;
  logic [ENTRY_W-1:0] s1_byp_r;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] entry_old;
  logic [ENTRY_W-1:0] entry_new;
  logic [LINE_W-1:0]  press;
  logic               accept;
  logic               s1_move;
  tick_t              tick;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keymap_low_r  <= KEYMAP_LOW_RST;
      keymap_high_r <= KEYMAP_HIGH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KEYMAP_LOW:  keymap_low_r  <= cfg_wr_data;
        REG_KEYMAP_HIGH: keymap_high_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = s1_valid_r && !s1_move;
  assign cur_row_nxt = (cur_row_r == ROW_W'(ROWS - 1)) ? '0 : cur_row_r + 1'b1;

  // Row-state memory: one entry per row, all columns of that row.
  kpsd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (s1_move),
    .wr_addr (s1_row_r),
    .wr_data (entry_new),
    .rd_en   (accept),
    .rd_addr (cur_row_r),
    .rd_data (rd_data)
  );

  // Control: row counter, stage valid and per-row written flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      s1_valid_r <= 1'b0;
      row_vld_r  <= '0;
    end else begin
      if (accept) begin
        cur_row_r <= cur_row_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        row_vld_r[s1_row_r] <= 1'b1;
      end
    end
  end

  // Stage payload; a write to the row being read is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r   <= cur_row_r;
      s1_lvl_r   <= in_column_levels;
      s1_drive_r <= ~(LINE_W'(1) << cur_row_nxt);
      s1_vld_r   <= row_vld_r[cur_row_r];
      s1_hit_r   <= s1_move && (s1_row_r == cur_row_r);
      s1_byp_r   <= entry_new;
    end
  end

  // A row never written reads as all keys released.
  assign entry_old = s1_hit_r ? s1_byp_r : (s1_vld_r ? rd_data : '1);

  kpsd_update #(
    .COLS             (COLS),
    .DEBOUNCE_SAMPLES (DEBOUNCE_SAMPLES)
  ) u_update (
    .entry_old (entry_old),
    .levels    (s1_lvl_r),
    .entry_new (entry_new),
    .press     (press)
  );

  assign tick.row   = 2'(s1_row_r);
  assign tick.drive = s1_drive_r;
  assign tick.mask  = press;

  kpsd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .tick_valid       (s1_valid_r),
    .tick_in          (tick),
    .tick_take        (s1_move),
    .keymap           ({keymap_high_r, keymap_low_r}),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_press_valid  (out_press_valid),
    .out_key_index    (out_key_index),
    .out_key_code     (out_key_code),
    .out_last_of_tick (out_last_of_tick)
  );

endmodule

// ----- src/kpsd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module kpsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; a same-edge write returns the old data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/kpsd_update.sv -----
// ----------------------------------------------------------------------------
// Row debounce update
// Shifts one row's column levels into the key histories and finds new presses.
// ----------------------------------------------------------------------------
module kpsd_update #(
  parameter int COLS             = 4,
  parameter int DEBOUNCE_SAMPLES = 4
) (
  input  logic [COLS*(DEBOUNCE_SAMPLES+1)-1:0] entry_old,
  input  logic [kpsd_pkg::LINE_W-1:0]          levels,
  output logic [COLS*(DEBOUNCE_SAMPLES+1)-1:0] entry_new,
  output logic [kpsd_pkg::LINE_W-1:0]          press
);
  import kpsd_pkg::*;

  localparam int EW = DEBOUNCE_SAMPLES + 1;

  // Each column holds a stable-released bit over its sample history.
  always_comb begin
    logic [DEBOUNCE_SAMPLES-1:0] h;
    logic                        released;
    entry_new = '0;
    press     = '0;
    for (int c = 0; c < COLS; c++) begin
      h        = {entry_old[c*EW +: DEBOUNCE_SAMPLES-1], levels[c]};
      released = entry_old[c*EW + DEBOUNCE_SAMPLES];
      if (h == '0) begin
        press[c] = released;
        released = 1'b0;
      end else if (&h) begin
        released = 1'b1;
      end
      entry_new[c*EW +: EW] = {released, h};
    end
  end

endmodule

// ----- src/kpsd_emit.sv -----
// ----------------------------------------------------------------------------
// Result emitter
// Holds one finished tick and sends its results one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module kpsd_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_valid,
  input  kpsd_pkg::tick_t              tick_in,
  output logic                         tick_take,
  input  logic [127:0]                 keymap,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kpsd_pkg::LINE_W-1:0]  out_row_drive,
  output logic                         out_press_valid,
  output logic [kpsd_pkg::INDEX_W-1:0] out_key_index,
  output logic [kpsd_pkg::CODE_W-1:0]  out_key_code,
  output logic                         out_last_of_tick
);
  import kpsd_pkg::*;

  logic        buf_valid_r;
  tick_t       buf_r;
  logic [LINE_W-1:0] mask_nxt;
  logic [1:0]  col;
  logic        any;
  logic        out_take;
  logic        free;

  // Pick the lowest pending press column.
  always_comb begin
    col = '0;
    any = 1'b0;
    for (int c = LINE_W - 1; c >= 0; c--) begin
      if (buf_r.mask[c]) begin
        col = 2'(c);
        any = 1'b1;
      end
    end
    mask_nxt = buf_r.mask & ~(LINE_W'(1) << col);
  end

  assign out_valid        = buf_valid_r;
  assign out_row_drive    = buf_r.drive;
  assign out_press_valid  = any;
  assign out_key_index    = any ? {buf_r.row, col} : '0;
  assign out_key_code     = any ? keymap[{buf_r.row, col, 3'b000} +: CODE_W] : '0;
  assign out_last_of_tick = !any || (mask_nxt == '0);

  assign out_take  = buf_valid_r && !out_stall;
  assign free      = !buf_valid_r || (out_take && out_last_of_tick);
  assign tick_take = tick_valid && free;

  // Buffer control: load a new tick when the buffer is empty or the last result of the old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else if (free) begin
      buf_valid_r <= tick_valid;
    end
  end

  // Buffer payload.
  always_ff @(posedge clk) begin
    if (tick_take) begin
      buf_r <= tick_in;
    end else if (out_take) begin
      buf_r.mask <= mask_nxt;
    end
  end

endmodule

// ----- src/kpsd_checker.sv -----
// ----------------------------------------------------------------------------
// Keypad scan checker
// Port-level assertions for the keypad scan core, attached by bind.
// ----------------------------------------------------------------------------
module kpsd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [kpsd_pkg::LINE_W-1:0]    out_row_drive,
  input logic                           out_press_valid,
  input logic [kpsd_pkg::INDEX_W-1:0]   out_key_index,
  input logic [kpsd_pkg::CODE_W-1:0]    out_key_code,
  input logic                           out_last_of_tick
);
  import kpsd_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_drive) &&
      $stable(out_key_index) && $stable(out_last_of_tick))
    else $error("stalled result changed");

  // Exactly one row is driven low.
  a_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(~out_row_drive))
    else $error("row drive pattern not one-cold");

  // A tick without presses is a single empty, final result.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_press_valid |->
      out_last_of_tick && out_key_index == '0 && out_key_code == '0)
    else $error("empty result malformed");

  // The result channel is empty right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind matrix_keypad_scan_debounce_core kpsd_checker u_kpsd_checker (.*);

// ----- bench/matrix_keypad_scan_debounce_core_tb.sv -----
// ----------------------------------------------------------------------------
// Keypad scan core testbench
// Sends scan ticks through the valid/stall input channel and checks every
// result against a local debounce and keymap model. A directed table comes
// first. Random phases follow, each under its own keymap and stall profile.
// ----------------------------------------------------------------------------
module matrix_keypad_scan_debounce_core_tb;
  import kpsd_pkg::*;

  // One result of the core, in port order.
  typedef struct packed {
    logic [LINE_W-1:0]  drive;
    logic               press;
    logic [INDEX_W-1:0] index;
    logic [CODE_W-1:0]  code;
    logic               last;
  } press_report_t;

  // One directed tick. When fixed is set, the report below is the only result expected.
  typedef struct packed {
    logic [LINE_W-1:0] levels;
    logic              fixed;
    press_report_t     rep;
  } scan_step_t;

  localparam int CLK_HALF       = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 150;
  localparam int DIR_STEPS      = 24;

  // Register indexes outside the map: writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEYMAP_LOW;
  logic [63:0]          cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LINE_W-1:0]    in_column_levels = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LINE_W-1:0]    out_row_drive;
  logic                 out_press_valid;
  logic [INDEX_W-1:0]   out_key_index;
  logic [CODE_W-1:0]    out_key_code;
  logic                 out_last_of_tick;

  // Fixed expectation traveling alongside the request payload.
  logic          req_fixed = 1'b0;
  press_report_t req_rep = '0;

  // Model state: keymap, row counter, per-key history and debounced state.
  logic [63:0]       km_low;
  logic [63:0]       km_high;
  logic [1:0]        scan_row;
  logic [3:0]        key_hist [16];
  logic              key_up [16];
  press_report_t     pending_reports [$];

  int   errors = 0;
  int   quiet_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  logic [1:0] stim_row = '0;

  // Directed ticks. Row 0 key 0 debounces to a press; row 1 goes fully low;
  // row 2 bounces before settling; row 3 holds column 3, then releases.
  scan_step_t dir_tab [DIR_STEPS] = '{
    '{4'hE, 1'b1, '{4'b1101, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b1011, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b0111, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h7, 1'b1, '{4'b1110, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'hE, 1'b1, '{4'b1101, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b1011, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'hF, 1'b1, '{4'b0111, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h7, 1'b1, '{4'b1110, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'hE, 1'b1, '{4'b1101, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b1011, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b0111, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h7, 1'b1, '{4'b1110, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'hE, 1'b1, '{4'b1101, 1'b1, 4'd0, 8'h31, 1'b1}},
    '{4'h0, 1'b0, '0},
    '{4'h0, 1'b1, '{4'b0111, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h7, 1'b0, '0},
    '{4'hF, 1'b1, '{4'b1101, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b1011, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b0111, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'hF, 1'b1, '{4'b1110, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'hE, 1'b1, '{4'b1101, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b1, '{4'b1011, 1'b0, 4'd0, 8'h00, 1'b1}},
    '{4'h0, 1'b0, '0},
    '{4'hF, 1'b1, '{4'b1110, 1'b0, 4'd0, 8'h00, 1'b1}}
  };

  matrix_keypad_scan_debounce_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_column_levels (in_column_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_drive    (out_row_drive),
    .out_press_valid  (out_press_valid),
    .out_key_index    (out_key_index),
    .out_key_code     (out_key_code),
    .out_last_of_tick (out_last_of_tick)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shift one tick into the scanned row and queue the press reports it causes.
  task automatic predict_scan(input logic [LINE_W-1:0] levels, input logic fixed,
                              input press_report_t fixed_rep);
    int            c;
    int            n;
    logic [3:0]    key;
    logic [3:0]    h;
    logic [3:0]    found [4];
    logic [3:0]    drive;
    press_report_t rep;
    n = 0;
    for (c = 0; c < 4; c++) begin
      key = {scan_row, 2'(c)};
      h = {key_hist[key][2:0], levels[c]};
      key_hist[key] = h;
      if (h == 4'h0) begin
        if (key_up[key]) begin
          found[n] = key;
          n++;
        end
        key_up[key] = 1'b0;
      end else if (h == 4'hF) begin
        key_up[key] = 1'b1;
      end
    end
    scan_row = scan_row + 2'd1;
    drive = ~(4'b0001 << scan_row);
    if (fixed) begin
      pending_reports.push_back(fixed_rep);
    end else if (n == 0) begin
      pending_reports.push_back('{drive, 1'b0, 4'd0, 8'h00, 1'b1});
    end else begin
      for (c = 0; c < n; c++) begin
        rep.drive = drive;
        rep.press = 1'b1;
        rep.index = found[c];
        rep.code  = found[c][3] ? km_high[8 * found[c][2:0] +: 8] : km_low[8 * found[c][2:0] +: 8];
        rep.last  = (c == n - 1);
        pending_reports.push_back(rep);
      end
    end
  endtask

  // Check results, then feed accepted requests to the model; watchdog on both.
  always @(posedge clk) begin
    press_report_t got;
    press_report_t want;
    if (rst_n) begin
      got = '{out_row_drive, out_press_valid, out_key_index, out_key_code, out_last_of_tick};
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result drive=%b press=%b index=%0d code=%h last=%b",
                   $time, got.drive, got.press, got.index, got.code, got.last);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected drive=%b press=%b index=%0d code=%h last=%b",
                     $time, want.drive, want.press, want.index, want.code, want.last);
            $display("%0t:          actual   drive=%b press=%b index=%0d code=%h last=%b",
                     $time, got.drive, got.press, got.index, got.code, got.last);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_scan(in_column_levels, req_fixed, req_rep);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[matrix_keypad_scan_debounce_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off once armed.
  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one request and return at the edge that accepts it.
  task automatic send_tick(input logic [LINE_W-1:0] levels, input logic fixed,
                           input press_report_t rep);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_column_levels <= levels;
    req_fixed        <= fixed;
    req_rep          <= rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stim_row = stim_row + 2'd1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_KEYMAP_LOW:  km_low = data;
      REG_KEYMAP_HIGH: km_high = data;
      default: ;
    endcase
  endtask

  // Reprogram both keymap words and poke an unmapped index; block must be idle.
  task automatic load_keymap(input logic [63:0] low_word, input logic [63:0] high_word);
    write_reg(REG_KEYMAP_LOW, low_word);
    write_reg($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, {$urandom, $urandom});
    write_reg(REG_KEYMAP_HIGH, high_word);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Drop the request, then let the model queue the last accepted request before waiting for the queue to empty.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random ticks: held key sets kept for several scan frames, with bounce and noise.
  task automatic run_scan_phase(input int n_items, input int idle_pct, input int stall_pct);
    int                i;
    int                frames_left;
    int                pick;
    logic [15:0]       held;
    logic [LINE_W-1:0] levels;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    frames_left = 0;
    held = '0;
    for (i = 0; i < n_items; i++) begin
      if (frames_left == 0) begin
        pick = $urandom_range(7);
        if (pick == 0) held = '0;
        else if (pick == 1) held = '1;
        else held = 16'($urandom & $urandom);
        frames_left = 4 * $urandom_range(3, 9);
      end
      levels = ~held[4 * stim_row +: 4];
      pick = $urandom_range(99);
      if (pick < 8) levels[$urandom_range(3)] = ~levels[$urandom_range(3)];
      else if (pick < 12) levels = 4'($urandom_range(15));
      send_tick(levels, 1'b0, '0);
      frames_left--;
    end
    drain();
  endtask

  initial begin
    int k;
    km_low   = KEYMAP_LOW_RST;
    km_high  = KEYMAP_HIGH_RST;
    scan_row = '0;
    for (k = 0; k < 16; k++) begin
      key_hist[k] = 4'hF;
      key_up[k]   = 1'b1;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks under the reset keymap.
    for (k = 0; k < DIR_STEPS; k++) begin
      send_tick(dir_tab[k].levels, dir_tab[k].fixed, dir_tab[k].rep);
    end
    drain();

    load_keymap('1, '0);
    run_scan_phase(PHASE_ITEMS, 32, 47);

    load_keymap({$urandom, $urandom}, '1);
    run_scan_phase(PHASE_ITEMS, 47, 32);

    // No idling here; the long hold-off makes the core back up into its input.
    load_keymap('0, {$urandom, $urandom});
    hold_arm = 1'b1;
    run_scan_phase(PHASE_ITEMS, 0, 0);

    repeat (8) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("[matrix_keypad_scan_debounce_core] OK");
    end else begin
      $display("[matrix_keypad_scan_debounce_core] ERROR");
    end
    $finish;
  end

endmodule
